// ===== hdl/per_stream_sequence_loss_counter_defines.svh =====
// Assertion helpers, sampled on clk and muted while arst_n is low.
`ifndef PER_STREAM_SEQUENCE_LOSS_COUNTER_DEFINES_SVH
`define PER_STREAM_SEQUENCE_LOSS_COUNTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pslc_pkg.sv =====
`default_nettype none
package pslc_pkg;

	localparam int SEQ_W = 64;
	localparam int ID_W = 64;
	localparam int SPAN_W = 63;
	localparam int ENTRIES_DEFAULT = 16;
	localparam logic [SEQ_W-1:0] MAX_GAP = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [SEQ_W-1:0] first;
		logic [SEQ_W-1:0] expected;
		logic [SEQ_W-1:0] lost;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_READ,
		S_CALC,
		S_UPDATE
	} state_t;

	// one strobe per datapath step
	typedef struct packed {
		logic capture;
		logic match;
		logic read;
		logic calc;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_blocked;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/per_stream_sequence_loss_counter.sv =====
// An accepted word passes through id match, entry read, calc and update in turn;
// out_valid rises when the update commits. No new word is taken while one is in
// flight; the input is taken again once the update commits, even while the result waits.
// The update holds while the result register still carries an untaken word.
// Reset (arst_n low, asynchronous) clears the stream valid bits, both sums,
// the controller state and out_valid; entry storage is not cleared.
`default_nettype none
module per_stream_sequence_loss_counter
	import pslc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [SEQ_W-1:0]  seq_number,
	input  wire logic [ID_W-1:0]   stream_id,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [SPAN_W-1:0]      total_span,
	output logic [SEQ_W-1:0]       total_lost,
	output logic                   stream_restarted,
	output logic                   table_full
);

	cmd_t cmd;
	sts_t sts;

	pslc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pslc_dp #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.seq_number       (seq_number),
		.stream_id        (stream_id),
		.total_span       (total_span),
		.total_lost       (total_lost),
		.stream_restarted (stream_restarted),
		.table_full       (table_full),
		.out_valid        (out_valid),
		.out_stall        (out_stall)
	);

endmodule
`default_nettype wire

// ===== hdl/pslc_ctrl.sv =====
`default_nettype none
module pslc_ctrl
	import pslc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_MATCH;
				end
			end
			S_MATCH:  state_d = S_READ;
			S_READ:   state_d = S_CALC;
			S_CALC:   state_d = S_UPDATE;
			S_UPDATE: begin
				// result register still holds an untaken word
				if (!sts.out_blocked) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
			end
			S_MATCH:  cmd.match = 1'b1;
			S_READ:   cmd.read = 1'b1;
			S_CALC:   cmd.calc = 1'b1;
			S_UPDATE: cmd.commit = !sts.out_blocked;
			default:  in_stall = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/pslc_cam.sv =====
`default_nettype none
module pslc_cam
	import pslc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT,
	localparam int SlotW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             match,
	input  wire logic [ID_W-1:0]  id,
	input  wire logic             wr_en,
	input  wire logic [SlotW-1:0] wr_slot,
	output logic                  hit,
	output logic                  full,
	output logic [SlotW-1:0]      slot
);

	logic [ENTRIES-1:0] valid_q;
	logic [ID_W-1:0]    id_q [ENTRIES];

	logic             hit_c;
	logic             free_c;
	logic [SlotW-1:0] hit_idx;
	logic [SlotW-1:0] free_idx;

	// lowest matching entry wins, else lowest free one
	always_comb begin
		hit_c = 1'b0;
		free_c = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (id_q[i] == id)) begin
				hit_c = 1'b1;
				hit_idx = SlotW'(i);
			end
			if (!valid_q[i]) begin
				free_c = 1'b1;
				free_idx = SlotW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q[wr_slot] <= id;
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			hit <= hit_c;
			full <= !hit_c && !free_c;
			slot <= hit_c ? hit_idx : free_idx;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/pslc_dp.sv =====
`default_nettype none
module pslc_dp
	import pslc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT,
	localparam int SlotW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [SEQ_W-1:0]  seq_number,
	input  wire logic [ID_W-1:0]   stream_id,
	output logic [SPAN_W-1:0]      total_span,
	output logic [SEQ_W-1:0]       total_lost,
	output logic                   stream_restarted,
	output logic                   table_full,
	output logic                   out_valid,
	input  wire logic              out_stall
);

	logic [SEQ_W-1:0] seq_q;
	logic [ID_W-1:0]  id_q;

	logic             hit;
	logic             full;
	logic [SlotW-1:0] slot;

	entry_t mem [ENTRIES];
	entry_t rd_q;
	entry_t new_entry_q;

	logic             restart_q;
	logic [SEQ_W-1:0] span_delta_q;
	logic [SEQ_W-1:0] lost_delta_q;
	logic [SEQ_W-1:0] sum_span_q;
	logic [SEQ_W-1:0] sum_lost_q;

	logic [SEQ_W-1:0] gap;
	logic [SEQ_W-1:0] seq_p1;
	logic             restart_c;
	logic [SEQ_W-1:0] new_span;
	logic [SEQ_W-1:0] new_lost;

	pslc_cam #(
		.ENTRIES(ENTRIES)
	) u_cam (
		.clk     (clk),
		.arst_n  (arst_n),
		.match   (cmd.match),
		.id      (id_q),
		.wr_en   (cmd.commit && restart_q),
		.wr_slot (slot),
		.hit     (hit),
		.full    (full),
		.slot    (slot)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_q <= seq_number;
			id_q <= stream_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_q <= mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !full) begin
			mem[slot] <= new_entry_q;
		end
	end

	assign gap = seq_q - rd_q.expected;
	assign seq_p1 = seq_q + 1'b1;
	assign restart_c = !hit || (rd_q.expected == '0) || (seq_q == '0)
		|| (seq_q < rd_q.expected) || (gap > MAX_GAP);

	// entry fields are only trusted on a hit
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			if (full) begin
				restart_q <= 1'b0;
				span_delta_q <= '0;
				lost_delta_q <= '0;
			end else if (restart_c) begin
				restart_q <= 1'b1;
				span_delta_q <= hit ? (rd_q.first - rd_q.expected + 1'b1) : SEQ_W'(1);
				lost_delta_q <= hit ? (SEQ_W'(0) - rd_q.lost) : '0;
			end else begin
				restart_q <= 1'b0;
				span_delta_q <= gap + 1'b1;
				lost_delta_q <= gap;
			end
			new_entry_q.first <= restart_c ? seq_q : rd_q.first;
			new_entry_q.expected <= seq_p1;
			new_entry_q.lost <= restart_c ? '0 : (rd_q.lost + gap);
		end
	end

	assign new_span = sum_span_q + span_delta_q;
	assign new_lost = sum_lost_q + lost_delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_span_q <= '0;
			sum_lost_q <= '0;
		end else if (cmd.commit) begin
			sum_span_q <= new_span;
			sum_lost_q <= new_lost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			total_span <= new_span[SEQ_W-1] ? '0 : new_span[SPAN_W-1:0];
			total_lost <= new_lost;
			stream_restarted <= restart_q;
			table_full <= full;
		end
	end

	assign sts.out_blocked = out_valid && out_stall;

`include "per_stream_sequence_loss_counter_defines.svh"

	`PSLC_ASSERT_NEXT(a_commit_shows_word, cmd.commit, out_valid,
		"committed word not presented")
	`PSLC_ASSERT_NOW(a_full_not_restart, out_valid && table_full, !stream_restarted,
		"dropped word flagged as restart")
	`PSLC_ASSERT_NEXT(a_full_keeps_sums, cmd.commit && full,
		(sum_span_q == $past(sum_span_q)) && (sum_lost_q == $past(sum_lost_q)),
		"sums changed on a dropped word")
	`PSLC_ASSERT_NOW(a_no_overwrite, cmd.commit, !(out_valid && out_stall),
		"commit over an untaken word")

endmodule
`default_nettype wire

// ===== dv/per_stream_sequence_loss_counter_checker.sv =====
module per_stream_sequence_loss_counter_checker
	import pslc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [SEQ_W-1:0]  seq_number,
	input  wire logic [ID_W-1:0]   stream_id,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [SPAN_W-1:0] total_span,
	input  wire logic [SEQ_W-1:0]  total_lost,
	input  wire logic              stream_restarted,
	input  wire logic              table_full,
	output int                     fail_count,
	output int                     pending_count
);

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic [SEQ_W-1:0]  lost;
		logic              restarted;
		logic              full;
	} loss_report_t;

	loss_report_t pending_reports [$];
	loss_report_t want;

	bit               stream_valid [ENTRIES];
	logic [ID_W-1:0]  stream_key   [ENTRIES];
	logic [SEQ_W-1:0] stream_first [ENTRIES];
	logic [SEQ_W-1:0] stream_next  [ENTRIES];
	logic [SEQ_W-1:0] stream_lost  [ENTRIES];
	logic [SEQ_W-1:0] span_sum;
	logic [SEQ_W-1:0] lost_sum;
	int               mismatches;

	function automatic loss_report_t account_packet(input logic [SEQ_W-1:0] seq,
		input logic [ID_W-1:0] id);
		loss_report_t     rep;
		int               slot;
		bit               fresh;
		bit               restart;
		logic [SEQ_W-1:0] exp_seq;
		logic [SEQ_W-1:0] gap;

		rep = '0;
		slot = -1;
		fresh = 1'b1;
		// lowest matching entry wins
		for (int i = 0; i < ENTRIES; i++) begin
			if (fresh && stream_valid[i] && stream_key[i] == id) begin
				slot = i;
				fresh = 1'b0;
			end
		end
		if (fresh) begin
			for (int i = ENTRIES - 1; i >= 0; i--) begin
				if (!stream_valid[i])
					slot = i;
			end
		end

		if (slot < 0) begin
			rep.full = 1'b1;
		end else begin
			exp_seq = fresh ? 64'd0 : stream_next[slot];
			gap = seq - exp_seq;
			restart = fresh || exp_seq == 64'd0 || seq == 64'd0 || seq < exp_seq ||
				gap > MAX_GAP;
			if (restart) begin
				if (!fresh) begin
					span_sum -= exp_seq - stream_first[slot];
					lost_sum -= stream_lost[slot];
				end
				stream_valid[slot] = 1'b1;
				stream_key[slot] = id;
				stream_first[slot] = seq;
				stream_next[slot] = seq + 64'd1;
				stream_lost[slot] = 64'd0;
				// (seq + 1) - seq is one even across the wrap
				span_sum += 64'd1;
				rep.restarted = 1'b1;
			end else begin
				stream_lost[slot] += gap;
				lost_sum += gap;
				span_sum += (seq + 64'd1) - exp_seq;
				stream_next[slot] = seq + 64'd1;
			end
		end

		rep.span = span_sum[SEQ_W-1] ? '0 : span_sum[SPAN_W-1:0];
		rep.lost = lost_sum;
		return rep;
	endfunction

	task automatic compare_field(input string name, input logic [SEQ_W-1:0] exp_val,
		input logic [SEQ_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				stream_valid[i] = 1'b0;
			span_sum = '0;
			lost_sum = '0;
			pending_reports.delete();
			mismatches = 0;
		end else begin
			// output first: a word taken this edge cannot have its result yet
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: unexpected result word, expected none actual span %h lost %h",
						$time, total_span, total_lost);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					compare_field("total_span", SEQ_W'(want.span), SEQ_W'(total_span));
					compare_field("total_lost", want.lost, total_lost);
					compare_field("stream_restarted", SEQ_W'(want.restarted),
						SEQ_W'(stream_restarted));
					compare_field("table_full", SEQ_W'(want.full), SEQ_W'(table_full));
				end
			end
			if (in_valid && !in_stall)
				pending_reports.push_back(account_packet(seq_number, stream_id));
		end
		pending_count <= pending_reports.size();
		fail_count <= mismatches;
	end

endmodule

// ===== dv/per_stream_sequence_loss_counter_tb.sv =====
module per_stream_sequence_loss_counter_tb;
	import pslc_pkg::*;

	localparam int NUM_STREAMS  = ENTRIES_DEFAULT;
	localparam int RANDOM_WORDS = 950;
	localparam int PHASES       = 5;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [SEQ_W-1:0]  seq_number;
	logic [ID_W-1:0]   stream_id;
	logic              out_valid;
	logic              out_stall;
	logic [SPAN_W-1:0] total_span;
	logic [SEQ_W-1:0]  total_lost;
	logic              stream_restarted;
	logic              table_full;

	int fail_count;
	int pending_count;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	logic [ID_W-1:0]  pool     [NUM_STREAMS];
	logic [SEQ_W-1:0] last_seq [NUM_STREAMS];

	per_stream_sequence_loss_counter u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.seq_number       (seq_number),
		.stream_id        (stream_id),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.total_span       (total_span),
		.total_lost       (total_lost),
		.stream_restarted (stream_restarted),
		.table_full       (table_full)
	);

	per_stream_sequence_loss_counter_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.seq_number       (seq_number),
		.stream_id        (stream_id),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.total_span       (total_span),
		.total_lost       (total_lost),
		.stream_restarted (stream_restarted),
		.table_full       (table_full),
		.fail_count       (fail_count),
		.pending_count    (pending_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// valid stays high across back-to-back words; lowered only for a gap
	task automatic send_word(input logic [SEQ_W-1:0] seq, input logic [ID_W-1:0] id);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		seq_number <= seq;
		stream_id <= id;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_stream(input int idx, input logic [SEQ_W-1:0] seq);
		last_seq[idx] = seq;
		send_word(seq, pool[idx]);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_count != 0);
	endtask

	initial begin
		int               pick;
		int               idx;
		int               g;
		logic [SEQ_W-1:0] gap;

		in_valid <= 1'b0;
		seq_number <= '0;
		stream_id <= '0;
		arst_n <= 1'b0;
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < NUM_STREAMS; i++)
			pool[i] = {$urandom, $urandom};
		for (int i = 0; i < NUM_STREAMS; i++)
			last_seq[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: new stream, in order, gap, below expected, zero seq,
		// largest legal gap, gap one past it, expected wrapping to zero
		send_stream(2, 64'd0);
		send_stream(2, 64'd1);
		send_stream(2, 64'd5);
		send_stream(2, 64'd3);
		send_stream(2, 64'd0);
		send_stream(2, 64'h1_0000_0000);
		send_stream(2, 64'h2_0000_0001);
		send_stream(3, '1);
		send_stream(3, 64'd5);
		send_stream(4, 64'hFFFF_FFFF_FFFF_FFFE);
		send_stream(4, '1);
		send_stream(4, 64'd7);
		send_stream(0, '1);
		send_stream(1, 64'd1);
		for (int i = 5; i < NUM_STREAMS; i++)
			send_stream(i, {$urandom, $urandom});
		// table is full now: an unknown id is dropped
		send_word({$urandom, $urandom}, {$urandom, $urandom});
		send_stream(2, last_seq[2] + 64'd1);
		in_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: begin
					idle_pct = 59;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 59;
				end
				3: begin
					idle_pct = 25;
					stall_pct <= 25;
				end
				default: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
			endcase
			for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
				pick = $urandom_range(99);
				idx = $urandom_range(NUM_STREAMS - 1);
				if (pick < 70) begin
					g = $urandom_range(99);
					if (g < 60)
						gap = '0;
					else if (g < 85)
						gap = SEQ_W'($urandom_range(16, 1));
					else if (g < 95)
						gap = SEQ_W'($urandom_range(32'hFFFF_FFFE, 17));
					else
						gap = MAX_GAP;
					send_stream(idx, last_seq[idx] + 64'd1 + gap);
				end else if (pick < 80) begin
					send_stream(idx, last_seq[idx] - SEQ_W'($urandom_range(100, 0)));
				end else if (pick < 85) begin
					send_stream(idx, last_seq[idx] + 64'h1_0000_0001 +
						SEQ_W'($urandom_range(1000, 0)));
				end else if (pick < 88) begin
					send_stream(idx, 64'd0);
				end else if (pick < 95) begin
					send_stream(idx, {$urandom, $urandom});
				end else begin
					send_word({$urandom, $urandom}, {$urandom, $urandom});
				end
			end
			// hold off until every result of this phase is out
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
